// File: sv/assert_macros.svh
// Assertion macros for the checker file of the echo request tracker.
// Depends on nothing; the user module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/eqt_pkg.sv
// Package of the echo request tracker: table size, status codes, token type.
// Depends on nothing; used by eqt_cell, echo_request_tracker and eqt_checker.
package eqt_pkg;

  localparam int unsigned SLOTS = 128;

  // Result status codes
  localparam logic [2:0] ST_SENT    = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_MATCHED = 3'd2;
  localparam logic [2:0] ST_SHORT   = 3'd3;
  localparam logic [2:0] ST_FOREIGN = 3'd4;
  localparam logic [2:0] ST_UNKNOWN = 3'd5;

  localparam logic [11:0] MIN_ICMP_BYTES = 12'd8;

  // Token that walks the slot chain, one cell per cycle
  typedef struct packed {
    logic        vld;   // token present in this stage
    logic        send;  // 1: request sent, 0: reply lookup
    logic        hit;   // a slot was claimed or matched upstream
    logic [15:0] seq;   // sequence to store or to look up
    logic [31:0] now;   // time stamp of the item
    logic [31:0] rtt;   // round-trip time once matched
  } tok_t;

endpackage

// File: sv/eqt_in_if.sv
// Input channel of the echo request tracker: valid/ready plus one item.
// Depends on nothing.
interface eqt_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] now_us;
  logic [11:0] packet_len;
  logic [3:0]  ip_header_words;
  logic [7:0]  msg_type;
  logic [15:0] reply_id;
  logic [15:0] reply_seq;

  modport source (
    output valid, op, now_us, packet_len, ip_header_words, msg_type, reply_id, reply_seq,
    input  ready
  );
  modport sink (
    input  valid, op, now_us, packet_len, ip_header_words, msg_type, reply_id, reply_seq,
    output ready
  );
endinterface

// File: sv/eqt_out_if.sv
// Result channel of the echo request tracker: valid/ready plus one result.
// Depends on nothing.
interface eqt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] seq_number;
  logic [31:0] round_trip_us;
  logic [11:0] icmp_len;
  logic [31:0] sent_total;
  logic [31:0] received_total;

  modport source (
    output valid, status, seq_number, round_trip_us, icmp_len, sent_total, received_total,
    input  ready
  );
  modport sink (
    input  valid, status, seq_number, round_trip_us, icmp_len, sent_total, received_total,
    output ready
  );
endinterface

// File: sv/eqt_cell.sv
// One slot of the tracking table: holds valid, sequence and send time,
// and passes the lookup token on to the next slot. Depends on eqt_pkg.
module eqt_cell
  import eqt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  tok_t tok_in,
  output tok_t tok_out
);

  logic        valid_r, valid_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [31:0] time_r, time_nxt;
  tok_t        tok_r, tok_nxt;
  logic        claim, match;

  // Claim a free slot for a send, or free a matching slot for a reply
  always_comb begin
    claim     = tok_in.vld && tok_in.send && !tok_in.hit && !valid_r;
    match     = tok_in.vld && !tok_in.send && !tok_in.hit && valid_r && (seq_r == tok_in.seq);
    valid_nxt = (valid_r && !match) || claim;
    seq_nxt   = claim ? tok_in.seq : seq_r;
    time_nxt  = claim ? tok_in.now : time_r;
    tok_nxt     = tok_in;
    tok_nxt.hit = tok_in.hit || claim || match;
    if (match) begin
      tok_nxt.rtt = tok_in.now - time_r;
    end
  end

  // Control state and token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // Slot contents
  always_ff @(posedge clk) begin
    seq_r  <= seq_nxt;
    time_r <= time_nxt;
  end

  assign tok_out = tok_r;

endmodule

// File: sv/echo_request_tracker.sv
// Echo request tracker: table of outstanding echo requests.
// Input channel in_beat: op 0 sends a request (takes the next sequence number
// and the lowest free slot), op 1 presents a received reply packet. Result
// channel out_beat: one result beat per input beat, with status, sequence,
// round-trip time, ICMP length and both running totals. cfg_we/cfg_wdata write
// the identifier that replies must carry; write it only while idle.
// Flow: a send or a reply that passes the header checks walks a chain of
// SLOTS cells, one cell per cycle; its result is staged and then loaded into
// the output register, and the next input beat is taken once that load is
// done. A reply rejected by the header checks skips the chain and goes
// straight to the result stage. One item is in flight at a time; the chain
// length sets the rate.
// Reset clears all slots, both totals and the identifier, and empties the
// output register. When the receiver stalls, the result beat is held in the
// output register and the next finished result waits until it is taken.
// Depends on eqt_pkg, eqt_in_if, eqt_out_if, eqt_cell.
module echo_request_tracker
  import eqt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  eqt_in_if.sink      in_beat,
  eqt_out_if.source   out_beat,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] send_cnt_r, send_cnt_nxt;
  logic [31:0] recv_cnt_r, recv_cnt_nxt;
  logic [15:0] my_id_r;
  tok_t        tok0_r, tok0_nxt;
  tok_t        tok_w [SLOTS+1];
  tok_t        tail;

  logic [2:0]  res_status_r, res_status_nxt;
  logic [15:0] res_seq_r, res_seq_nxt;
  logic [31:0] res_rtt_r, res_rtt_nxt;
  logic [11:0] res_ilen_r, res_ilen_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r;
  logic [15:0] out_seq_r;
  logic [31:0] out_rtt_r;
  logic [11:0] out_ilen_r;
  logic [31:0] out_sent_r;
  logic [31:0] out_recv_r;
  logic        out_ld;

  logic        accept;
  logic [5:0]  hdr_bytes;
  logic [12:0] icmp_diff;
  logic        too_short;
  logic        foreign;

  assign in_beat.ready = (state_r == S_IDLE);
  assign accept        = in_beat.valid && in_beat.ready;
  assign tail          = tok_w[SLOTS];

  // Header checks on the incoming reply
  always_comb begin
    hdr_bytes = {in_beat.ip_header_words, 2'b00};
    icmp_diff = {1'b0, in_beat.packet_len} - {7'd0, hdr_bytes};
    too_short = icmp_diff[12] || (icmp_diff[11:0] < MIN_ICMP_BYTES);
    foreign   = (in_beat.msg_type != 8'd0) || (in_beat.reply_id != my_id_r);
  end

  // Sequence the item: launch token, collect result, hand it to the output
  always_comb begin
    state_nxt      = state_r;
    send_cnt_nxt   = send_cnt_r;
    recv_cnt_nxt   = recv_cnt_r;
    tok0_nxt       = tok0_r;
    tok0_nxt.vld   = 1'b0;
    res_status_nxt = res_status_r;
    res_seq_nxt    = res_seq_r;
    res_rtt_nxt    = res_rtt_r;
    res_ilen_nxt   = res_ilen_r;
    out_ld         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          tok0_nxt.hit = 1'b0;
          tok0_nxt.now = in_beat.now_us;
          tok0_nxt.rtt = 32'd0;
          if (!in_beat.op) begin
            send_cnt_nxt  = send_cnt_r + 32'd1;
            tok0_nxt.vld  = 1'b1;
            tok0_nxt.send = 1'b1;
            tok0_nxt.seq  = send_cnt_nxt[15:0];
            res_ilen_nxt  = 12'd0;
            state_nxt     = S_SCAN;
          end else if (too_short) begin
            res_status_nxt = ST_SHORT;
            res_seq_nxt    = 16'd0;
            res_rtt_nxt    = 32'd0;
            res_ilen_nxt   = 12'd0;
            state_nxt      = S_FIN;
          end else if (foreign) begin
            res_status_nxt = ST_FOREIGN;
            res_seq_nxt    = 16'd0;
            res_rtt_nxt    = 32'd0;
            res_ilen_nxt   = icmp_diff[11:0];
            state_nxt      = S_FIN;
          end else begin
            tok0_nxt.vld  = 1'b1;
            tok0_nxt.send = 1'b0;
            tok0_nxt.seq  = in_beat.reply_seq;
            res_ilen_nxt  = icmp_diff[11:0];
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (tail.vld) begin
          state_nxt = S_FIN;
          if (tail.send) begin
            res_status_nxt = tail.hit ? ST_SENT : ST_FULL;
            res_seq_nxt    = tail.seq;
            res_rtt_nxt    = 32'd0;
          end else if (tail.hit) begin
            res_status_nxt = ST_MATCHED;
            res_seq_nxt    = tail.seq;
            res_rtt_nxt    = tail.rtt;
            recv_cnt_nxt   = recv_cnt_r + 32'd1;
          end else begin
            res_status_nxt = ST_UNKNOWN;
            res_seq_nxt    = 16'd0;
            res_rtt_nxt    = 32'd0;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_beat.ready) begin
          out_ld    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = out_ld || (out_valid_r && !out_beat.ready);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      send_cnt_r  <= 32'd0;
      recv_cnt_r  <= 32'd0;
      my_id_r     <= 16'd0;
      tok0_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      send_cnt_r  <= send_cnt_nxt;
      recv_cnt_r  <= recv_cnt_nxt;
      tok0_r      <= tok0_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        my_id_r <= cfg_wdata;
      end
    end
  end

  // Result staging and output register
  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_seq_r    <= res_seq_nxt;
    res_rtt_r    <= res_rtt_nxt;
    res_ilen_r   <= res_ilen_nxt;
    if (out_ld) begin
      out_status_r <= res_status_r;
      out_seq_r    <= res_seq_r;
      out_rtt_r    <= res_rtt_r;
      out_ilen_r   <= res_ilen_r;
      out_sent_r   <= send_cnt_r;
      out_recv_r   <= recv_cnt_r;
    end
  end

  // Chain of slot cells
  assign tok_w[0] = tok0_r;
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    eqt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok_w[k]),
      .tok_out (tok_w[k+1])
    );
  end

  assign out_beat.valid          = out_valid_r;
  assign out_beat.status         = out_status_r;
  assign out_beat.seq_number     = out_seq_r;
  assign out_beat.round_trip_us  = out_rtt_r;
  assign out_beat.icmp_len       = out_ilen_r;
  assign out_beat.sent_total     = out_sent_r;
  assign out_beat.received_total = out_recv_r;

endmodule

// File: sv/eqt_checker.sv
// Port-level checks for the echo request tracker, bound to the top level.
// Depends on eqt_pkg, eqt_in_if, eqt_out_if and assert_macros.svh.
`include "assert_macros.svh"

module eqt_checker
  import eqt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  eqt_in_if.sink    in_beat,
  eqt_out_if.source out_beat
);

  // Hold a stalled result beat
  `ASSERT_CLK(a_out_hold, out_beat.valid && !out_beat.ready |=> out_beat.valid && $stable(out_beat.status) && $stable(out_beat.sent_total), "stalled result beat changed")

  // Take one item at a time
  `ASSERT_CLK(a_one_item, in_beat.valid && in_beat.ready |=> !in_beat.ready, "input taken while an item is in flight")

  // Report a too short reply with empty fields
  `ASSERT_CLK(a_short_empty, out_beat.valid && out_beat.status == ST_SHORT |-> out_beat.seq_number == 16'd0 && out_beat.round_trip_us == 32'd0 && out_beat.icmp_len == 12'd0, "short reply result has data")

  // Empty the output after reset
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_beat.valid, "result beat valid after reset")

endmodule

bind echo_request_tracker eqt_checker u_eqt_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_beat  (in_beat),
  .out_beat (out_beat)
);
